FILE: sv/spla_pkg.sv
// Shared types and constants for the slot pool lifecycle allocator.
// No dependencies; imported by the top level.
package spla_pkg;

  localparam int MaxSlotsDef = 16;
  localparam int DefaultSlots = 16;
  localparam int CountW = 5;
  localparam int BasePortW = 16;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW = 1;
  localparam int KindW = 3;
  localparam int SlotIdxW = 8;
  localparam int ProcW = 32;
  localparam int TagW = 64;
  localparam int GrantIdxW = 4;
  localparam int PortW = 17;

  localparam logic [CfgIdxW-1:0] CfgSlotCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBasePort = 1'd1;

  typedef enum logic [KindW-1:0] {
    KIND_START     = 3'd0,
    KIND_READY     = 3'd1,
    KIND_ALLOCATE  = 3'd2,
    KIND_IN_MATCH  = 3'd3,
    KIND_RELEASING = 3'd4,
    KIND_RELEASE   = 3'd5,
    KIND_FAILED    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_STARTING  = 3'd1,
    ST_READY     = 3'd2,
    ST_ALLOCATED = 3'd3,
    ST_IN_MATCH  = 3'd4,
    ST_RELEASING = 3'd5,
    ST_FAILED    = 3'd6
  } slot_st_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL
  } fsm_e;

  typedef struct packed {
    slot_st_e          state;
    logic [ProcW-1:0]  process;
    logic [TagW-1:0]   tag_high;
    logic [TagW-1:0]   tag_low;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

FILE: sv/spla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/slot_pool_lifecycle_allocator.sv
// Slot pool lifecycle allocator: slot table in one RAM, scan sequencer, result register.
// Depends on spla_pkg and spla_ram.
//
// Usage:
//  - Events enter on start_i with kind_i, slot_index_i, process_id_i and the
//    128-bit tag (match_tag_high_i/match_tag_low_i). A beat is taken when
//    start_i is high and busy_o is low; busy_o then stays high until the
//    event is finished.
//  - Each event returns one result beat: done_o is high for exactly one
//    cycle with ok_o and the granted_* fields. The receiver cannot stall.
//  - Sequence: addressed events (start, ready, in_match, releasing, failed)
//    and unknown kinds pass READ and EVAL once, then the result register.
//    Allocate and release walk the table one slot per cycle through the
//    single RAM read port and the shared compare unit, stopping at the
//    first hit or at slot_count - 1 (an allocate with an all-zero tag
//    walks the whole table). busy_o drops with done_o, so the next event
//    can be taken in the cycle its result is shown.
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (0 slot_count, 1 base_port). The user writes only while idle; the
//    block does not enforce it. Writing slot_count clamps it to 1..MaxSlots
//    and clears the table at once by dropping every per-slot valid bit.
//  - Reset: asynchronous, active low. All valid bits clear (every slot reads
//    idle with zero process and tag), slot_count = min(16, MaxSlots),
//    base_port = 0, no result pending.
module slot_pool_lifecycle_allocator
  import spla_pkg::*;
#(
  parameter int MaxSlots = MaxSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [KindW-1:0]     kind_i,
  input  logic [SlotIdxW-1:0]  slot_index_i,
  input  logic [ProcW-1:0]     process_id_i,
  input  logic [TagW-1:0]      match_tag_high_i,
  input  logic [TagW-1:0]      match_tag_low_i,
  output logic                 done_o,
  output logic                 ok_o,
  output logic [GrantIdxW-1:0] granted_index_o,
  output logic [PortW-1:0]     granted_port_o,
  output logic [ProcW-1:0]     granted_process_o,
  output logic [2:0]           granted_state_o
);

  localparam int IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int ResetCount = (DefaultSlots > MaxSlots) ? MaxSlots : DefaultSlots;

  // Clamp a written slot_count into 1..MaxSlots.
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CountW'(1);
    end else if (int'(v) > MaxSlots) begin
      r = CountW'(MaxSlots);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CountW-1:0]    count_q;
  logic [BasePortW-1:0] base_q;
  logic [MaxSlots-1:0]  vld_q, vld_d;

  // Sequencer and latched event.
  fsm_e                fsm_q, fsm_d;
  logic [IdxW-1:0]     e_q, e_d;
  logic [KindW-1:0]    kind_q;
  logic                rng_q;
  logic [IdxW-1:0]     s_q;
  logic [ProcW-1:0]    pid_q;
  logic [TagW-1:0]     tag_hi_q, tag_lo_q;

  // Result register.
  logic                done_q, done_d;
  logic                ok_q, ok_d;
  logic [GrantIdxW-1:0] gidx_q, gidx_d;
  logic [PortW-1:0]    gport_q, gport_d;
  logic [ProcW-1:0]    gproc_q, gproc_d;
  logic [2:0]          gst_q, gst_d;

  // Table access.
  logic                ram_we;
  logic [IdxW-1:0]     ram_raddr;
  logic [EntryW-1:0]   ram_rdata;
  entry_t              ent, wr_ent;

  logic                accept, in_rng, is_scan, last, hit, finish, tag_eq;
  logic [SlotIdxW-1:0] e_ext;

  assign accept = start_i && (fsm_q == FSM_IDLE);
  assign in_rng = slot_index_i < SlotIdxW'(count_q);

  spla_ram #(
    .Width(EntryW),
    .Depth(MaxSlots)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(e_q),
    .wdata_i(wr_ent),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A slot never written since the last clear reads as its reset contents.
  assign ent = vld_q[e_q] ? entry_t'(ram_rdata) : entry_t'('0);

  assign is_scan = (kind_e'(kind_q) == KIND_ALLOCATE) || (kind_e'(kind_q) == KIND_RELEASE);
  assign e_ext   = SlotIdxW'(e_q);
  assign last    = e_ext == (SlotIdxW'(count_q) - SlotIdxW'(1));
  assign tag_eq  = (ent.tag_high == tag_hi_q) && (ent.tag_low == tag_lo_q);

  // Shared evaluate unit: decide on the slot whose data sits on the read port.
  always_comb begin
    hit    = 1'b0;
    wr_ent = ent;
    case (kind_e'(kind_q))
      KIND_START: begin
        hit             = rng_q && (pid_q != '0);
        wr_ent.state    = ST_STARTING;
        wr_ent.process  = pid_q;
        wr_ent.tag_high = '0;
        wr_ent.tag_low  = '0;
      end
      KIND_READY: begin
        hit             = rng_q && (ent.state == ST_STARTING) && (ent.process == pid_q);
        wr_ent.state    = ST_READY;
        wr_ent.tag_high = '0;
        wr_ent.tag_low  = '0;
      end
      KIND_ALLOCATE: begin
        hit             = ((tag_hi_q != '0) || (tag_lo_q != '0)) && (ent.state == ST_READY);
        wr_ent.state    = ST_ALLOCATED;
        wr_ent.tag_high = tag_hi_q;
        wr_ent.tag_low  = tag_lo_q;
      end
      KIND_IN_MATCH: begin
        hit          = rng_q && (ent.state == ST_ALLOCATED) && tag_eq;
        wr_ent.state = ST_IN_MATCH;
      end
      KIND_RELEASING: begin
        hit          = rng_q && tag_eq &&
                       ((ent.state == ST_ALLOCATED) || (ent.state == ST_IN_MATCH));
        wr_ent.state = ST_RELEASING;
      end
      KIND_RELEASE: begin
        hit             = (ent.state == ST_ALLOCATED) && tag_eq;
        wr_ent.state    = ST_READY;
        wr_ent.tag_high = '0;
        wr_ent.tag_low  = '0;
      end
      KIND_FAILED: begin
        hit             = rng_q;
        wr_ent.state    = ST_FAILED;
        wr_ent.process  = '0;
        wr_ent.tag_high = '0;
        wr_ent.tag_low  = '0;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign finish = (fsm_q == FSM_EVAL) && (hit || !is_scan || last);

  // Next state.
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      FSM_IDLE: begin
        if (start_i) begin
          fsm_d = FSM_READ;
        end
      end
      FSM_READ: begin
        fsm_d = FSM_EVAL;
      end
      FSM_EVAL: begin
        if (finish) begin
          fsm_d = FSM_IDLE;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  // Sequencer outputs: read address, scan index, table write, result beat.
  always_comb begin
    busy_o    = fsm_q != FSM_IDLE;
    ram_raddr = e_q;
    e_d       = e_q;
    ram_we    = 1'b0;
    vld_d     = vld_q;
    done_d    = 1'b0;
    ok_d      = 1'b0;
    gidx_d    = '0;
    gport_d   = '0;
    gproc_d   = '0;
    gst_d     = '0;
    case (fsm_q)
      FSM_READ: begin
        // Scans start at slot zero; addressed events read their slot.
        ram_raddr = is_scan ? '0 : s_q;
        e_d       = ram_raddr;
      end
      FSM_EVAL: begin
        // Advance the scan: fetch the next slot while this one is judged.
        if (!finish) begin
          ram_raddr = e_q + IdxW'(1);
          e_d       = ram_raddr;
        end
        if (hit) begin
          ram_we     = 1'b1;
          vld_d[e_q] = 1'b1;
        end
        done_d = finish;
        ok_d   = hit;
        if (hit && (kind_e'(kind_q) == KIND_ALLOCATE)) begin
          gidx_d  = e_ext[GrantIdxW-1:0];
          gport_d = PortW'(base_q) + PortW'(e_q);
          gproc_d = ent.process;
          gst_d   = ST_ALLOCATED;
        end
      end
      default: begin
        ram_raddr = e_q;
      end
    endcase
    // Writing slot_count drops the whole table.
    if (cfg_we_i && (cfg_idx_i == CfgSlotCount)) begin
      vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q   <= FSM_IDLE;
      e_q     <= '0;
      vld_q   <= '0;
      count_q <= CountW'(ResetCount);
      base_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      e_q    <= e_d;
      vld_q  <= vld_d;
      done_q <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSlotCount: count_q <= clamp_count(cfg_data_i[CountW-1:0]);
          CfgBasePort:  base_q  <= cfg_data_i[BasePortW-1:0];
          default:      base_q  <= base_q;
        endcase
      end
    end
  end

  // Event and result payload: hold the event beat for the whole walk.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      rng_q    <= in_rng;
      s_q      <= in_rng ? slot_index_i[IdxW-1:0] : '0;
      pid_q    <= process_id_i;
      tag_hi_q <= match_tag_high_i;
      tag_lo_q <= match_tag_low_i;
    end
    if (done_d) begin
      ok_q    <= ok_d;
      gidx_q  <= gidx_d;
      gport_q <= gport_d;
      gproc_q <= gproc_d;
      gst_q   <= gst_d;
    end
  end

  assign done_o            = done_q;
  assign ok_o              = ok_q;
  assign granted_index_o   = gidx_q;
  assign granted_port_o    = gport_q;
  assign granted_process_o = gproc_q;
  assign granted_state_o   = gst_q;

  // The result beat comes in the cycle the sequencer returns to idle.
  a_done_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result beat");

  // An accepted event keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted event did not occupy the sequencer");

  // A rejected event carries all-zero grant fields.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> ((granted_port_o == '0) && (granted_process_o == '0) &&
                           (granted_state_o == '0) && (granted_index_o == '0)))
    else $error("rejected event reported a grant");

  // A grant state only appears on a successful event.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (granted_state_o != '0)) |-> ok_o)
    else $error("grant reported without success");

endmodule
